### hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg - shared constants for the epoch seconds to calendar converter
// Widths, period lengths in seconds and the month length table.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned ALU_W   = 33;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [6:0]        EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400 = 9'd370;

  localparam logic [EPOCH_W-1:0] SECS_MINUTE    = 32'd60;
  localparam logic [EPOCH_W-1:0] SECS_HOUR      = 32'd3600;
  localparam logic [EPOCH_W-1:0] SECS_DAY       = 32'd86400;
  localparam logic [EPOCH_W-1:0] SECS_YEAR      = 32'd31536000;
  localparam logic [EPOCH_W-1:0] SECS_LEAP_YEAR = 32'd31622400;

  // Thursday, 1970-01-01, counted from Sunday as zero
  localparam logic [2:0] EPOCH_WDAY = 3'd4;
  localparam logic [3:0] WEEK_DAYS  = 4'd7;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Days in a month, February lengthened in leap years
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:      len = 5'd31;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      4'd3:      len = 5'd31;
      4'd4:      len = 5'd30;
      4'd5:      len = 5'd31;
      4'd6:      len = 5'd30;
      4'd7:      len = 5'd31;
      4'd8:      len = 5'd31;
      4'd9:      len = 5'd30;
      4'd10:     len = 5'd31;
      4'd11:     len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

  // Seconds in a month of the given length in days
  function automatic logic [EPOCH_W-1:0] month_secs(input logic [4:0] len);
    logic [EPOCH_W-1:0] secs;
    case (len)
      5'd28:   secs = 32'd2419200;
      5'd29:   secs = 32'd2505600;
      5'd30:   secs = 32'd2592000;
      default: secs = 32'd2678400;
    endcase
    return secs;
  endfunction

endpackage

### hdl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar - Unix seconds to Gregorian date and time
// Iterative converter built around one shared 33-bit subtract/compare unit.
// ----------------------------------------------------------------------------
// One transaction in carries an unsigned 32-bit count of seconds since
// 1970-01-01 00:00:00; one transaction out carries second, minute, hour,
// weekday (1 Sunday .. 7 Saturday), day of month, month and year. The block
// takes one conversion at a time: in_tready is high only while the sequencer
// is idle. All of the work runs through a single subtractor that peels whole
// periods off the seconds count: years stepped from 1970, then months stepped
// from January, then whole days, hours and minutes, with a closing step at
// the end of each search. The weekday advances alongside by each period's
// length modulo 7. The time taken grows with the year, month, day of month,
// hour and minute of the result. A new input transaction is taken only once
// the sequencer has returned to idle after posting the result. A finished
// result waits in the output register; a conversion that finishes while the
// previous result is still held parks in its last step until the output
// register frees up.
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [5:0] second_of_minute, [11:6] minute_of_hour,
                                  // [16:12] hour_of_day, [19:17] weekday,
                                  // [24:20] day_of_month, [28:25] month_number,
                                  // [40:29] year_number, [47:41] zero
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_HOLD
  } state_t;

  state_t              state_r,  state_nxt;
  logic [EPOCH_W-1:0]  rem_r,    rem_nxt;    // seconds not yet stepped off
  logic [YEAR_W-1:0]   year_r,   year_nxt;
  logic [6:0]          c100_r,   c100_nxt;
  logic [8:0]          c400_r,   c400_nxt;
  logic [3:0]          month_r,  month_nxt;
  logic [4:0]          mday_r,   mday_nxt;   // whole days within the month
  logic [4:0]          hour_r,   hour_nxt;
  logic [5:0]          min_r,    min_nxt;
  logic [2:0]          wday_r,   wday_nxt;   // 0 Sunday .. 6 Saturday
  logic                ovld_r,   ovld_nxt;
  logic [47:0]         odata_r,  odata_nxt;

  // Shared subtract/compare unit
  logic [EPOCH_W-1:0] alu_b;
  logic [ALU_W-1:0]   alu_diff;
  logic               alu_ge;

  logic               leap;
  logic [4:0]         mlen;
  logic [1:0]         wday_inc;
  logic [3:0]         wday_sum;
  logic [2:0]         wday_step;
  logic               out_free;

  assign leap     = (c400_r == 9'd0) || ((c100_r != 7'd0) && (year_r[1:0] == 2'b00));
  assign mlen     = month_days(month_r, leap);
  assign out_free = !ovld_r || out_tready;

  // Operand select: the period being stepped off and its length modulo 7
  always_comb begin
    case (state_r)
      ST_YEAR: begin
        alu_b    = leap ? SECS_LEAP_YEAR : SECS_YEAR;
        wday_inc = leap ? 2'd2 : 2'd1;
      end
      ST_MONTH: begin
        alu_b    = month_secs(mlen);
        // 28..31 days leave 0..3 modulo 7
        wday_inc = mlen[1:0];
      end
      ST_DAY: begin
        alu_b    = SECS_DAY;
        wday_inc = 2'd1;
      end
      ST_HOUR: begin
        alu_b    = SECS_HOUR;
        wday_inc = 2'd0;
      end
      default: begin
        alu_b    = SECS_MINUTE;
        wday_inc = 2'd0;
      end
    endcase
  end

  assign alu_diff = {1'b0, rem_r} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[ALU_W-1];

  // Advance the weekday modulo 7
  assign wday_sum  = {1'b0, wday_r} + {2'b00, wday_inc};
  assign wday_step = (wday_sum >= WEEK_DAYS) ? 3'(wday_sum - WEEK_DAYS) : wday_sum[2:0];

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    year_nxt  = year_r;
    c100_nxt  = c100_r;
    c400_nxt  = c400_r;
    month_nxt = month_r;
    mday_nxt  = mday_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    wday_nxt  = wday_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;

    // drop the posted result once taken
    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_YEAR;
          rem_nxt   = in_tdata;
          year_nxt  = EPOCH_YEAR;
          c100_nxt  = EPOCH_MOD100;
          c400_nxt  = EPOCH_MOD400;
          wday_nxt  = EPOCH_WDAY;
        end
      end

      ST_YEAR: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff[EPOCH_W-1:0];
          year_nxt = year_r + 12'd1;
          c100_nxt = (c100_r == 7'd99)  ? 7'd0 : c100_r + 7'd1;
          c400_nxt = (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
          wday_nxt = wday_step;
        end else begin
          state_nxt = ST_MONTH;
          month_nxt = 4'd1;
        end
      end

      ST_MONTH: begin
        // December takes whatever remains
        if (!alu_ge || (month_r == MONTH_DEC)) begin
          state_nxt = ST_DAY;
          mday_nxt  = 5'd0;
        end else begin
          rem_nxt   = alu_diff[EPOCH_W-1:0];
          month_nxt = month_r + 4'd1;
          wday_nxt  = wday_step;
        end
      end

      ST_DAY: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff[EPOCH_W-1:0];
          mday_nxt = mday_r + 5'd1;
          wday_nxt = wday_step;
        end else begin
          state_nxt = ST_HOUR;
          hour_nxt  = 5'd0;
        end
      end

      ST_HOUR: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff[EPOCH_W-1:0];
          hour_nxt = hour_r + 5'd1;
        end else begin
          state_nxt = ST_MIN;
          min_nxt   = 6'd0;
        end
      end

      ST_MIN: begin
        if (alu_ge) begin
          rem_nxt = alu_diff[EPOCH_W-1:0];
          min_nxt = min_r + 6'd1;
        end else begin
          state_nxt = ST_HOLD;
        end
      end

      ST_HOLD: begin
        // hold until the output register is free; the remainder is the second
        if (out_free) begin
          ovld_nxt  = 1'b1;
          odata_nxt = {7'd0, year_r, month_r, mday_r + 5'd1, wday_r + 3'd1,
                       hour_r, min_r, rem_r[5:0]};
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    rem_r   <= rem_nxt;
    year_r  <= year_nxt;
    c100_r  <= c100_nxt;
    c400_r  <= c400_nxt;
    month_r <= month_nxt;
    mday_r  <= mday_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    wday_r  <= wday_nxt;
    odata_r <= odata_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

`ifndef SYNTHESIS
  // minute stepping starts below one hour of remaining seconds
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIN) |-> (rem_r < SECS_HOUR))
    else $error("minute remainder out of range");

  // month stepping stays within January..December
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) |-> ((month_r >= 4'd1) && (month_r <= MONTH_DEC)))
    else $error("month counter out of range");

  // posted time-of-day and weekday fields are in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[5:0] < 6'd60) && (out_tdata[11:6] < 6'd60) &&
                    (out_tdata[16:12] < 5'd24) && (out_tdata[19:17] != 3'd0)))
    else $error("result field out of range");

  // a posted result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("pending result lost");
`endif

endmodule

### bench/tb_epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar - self-checking bench for the Unix time converter
// Drives a table of edge dates and then about 530 random or boundary-hugging
// timestamps through the stream input, predicts each calendar result and
// checks every output transaction field by field, under random back-pressure.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 530;
  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no transaction
  localparam int unsigned DRAIN_CYCLES = 300;   // longer than the worst-case conversion
  localparam int unsigned DAY_SECONDS  = 86400;

  localparam logic [2:0] WD_SUNDAY   = 3'd1;
  localparam logic [2:0] WD_THURSDAY = 3'd5;

  localparam int unsigned MONTH_LEN[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Output word, highest field first so it overlays out_tdata directly
  typedef struct packed {
    logic [6:0]  pad;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  typedef struct {
    logic [31:0] secs;
    cal_t        date;
  } dated_t;

  typedef struct {
    logic [31:0] secs;
    bit          typed;   // expected date written out by hand
    cal_t        date;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] epoch_seconds
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [5:0] second, [11:6] minute, [16:12] hour,
                                // [19:17] weekday, [24:20] day, [28:25] month,
                                // [40:29] year, [47:41] zero

  dated_t      pending_dates[$];
  int unsigned date_errors = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  bit          steady_run = 1'b0;   // suppress idling on both sides

  always #6 clk = ~clk;

  epoch_seconds_to_calendar dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned mo, input bit leap);
    return MONTH_LEN[mo-1] + ((leap && mo == 2) ? 1 : 0);
  endfunction

  function automatic cal_t stamp(input int unsigned sec, input int unsigned minute,
                                 input int unsigned hour, input logic [2:0] wday,
                                 input int unsigned mday, input int unsigned month,
                                 input int unsigned year);
    cal_t c;
    c        = '0;
    c.second = 6'(sec);
    c.minute = 6'(minute);
    c.hour   = 5'(hour);
    c.wday   = wday;
    c.mday   = 5'(mday);
    c.month  = 4'(month);
    c.year   = 12'(year);
    return c;
  endfunction

  // Expected calendar date for a count of seconds since the epoch
  function automatic cal_t calendar_of(input logic [31:0] secs);
    int unsigned rest, days, yr, mo, wday;
    bit          leap;
    rest = secs;
    days = rest / DAY_SECONDS;
    // the epoch fell on a Thursday
    wday = (days + 4) % 7 + 1;
    yr   = 1970;
    leap = is_leap(yr);
    while (days >= (leap ? 366 : 365)) begin
      days -= leap ? 366 : 365;
      yr++;
      leap = is_leap(yr);
    end
    mo = 1;
    while (mo < 12 && days >= month_length(mo, leap)) begin
      days -= month_length(mo, leap);
      mo++;
    end
    return stamp(rest % 60, (rest / 60) % 60, (rest / 3600) % 24, 3'(wday), days + 1,
                 mo, yr);
  endfunction

  function automatic longint days_to_month_start(input int unsigned yr, input int unsigned mo);
    longint days;
    days = 0;
    for (int unsigned y = 1970; y < yr; y++) days += is_leap(y) ? 366 : 365;
    for (int unsigned m = 1; m < mo; m++) days += longint'(month_length(m, is_leap(yr)));
    return days;
  endfunction

  // Timestamps near year and month turnovers, where the searches are touchiest
  function automatic logic [31:0] near_boundary();
    longint base;
    int     offset;
    base = days_to_month_start($urandom_range(1970, 2105), $urandom_range(1, 12)) *
           DAY_SECONDS;
    case ($urandom_range(0, 2))
      0:       offset = -1;
      1:       offset = 0;
      default: offset = int'($urandom_range(0, 4 * DAY_SECONDS)) - 2 * DAY_SECONDS;
    endcase
    // a step back from the epoch wraps to the top of the range, still legal
    return 32'(base + offset);
  endfunction

  function automatic string bad_fields(input cal_t got, input cal_t want);
    string s;
    s = "";
    if (got.second != want.second) s = {s, " second"};
    if (got.minute != want.minute) s = {s, " minute"};
    if (got.hour   != want.hour)   s = {s, " hour"};
    if (got.wday   != want.wday)   s = {s, " weekday"};
    if (got.mday   != want.mday)   s = {s, " day"};
    if (got.month  != want.month)  s = {s, " month"};
    if (got.year   != want.year)   s = {s, " year"};
    if (got.pad    != want.pad)    s = {s, " padding"};
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: compare each output transaction with the oldest date
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cal_t   got;
    dated_t exp_date;
    string  diff;
    if (rst_n && out_tvalid && out_tready) begin
      got = cal_t'(out_tdata);
      results_seen++;
      if (pending_dates.size() == 0) begin
        date_errors++;
        if (date_errors <= 10)
          $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                   got.year, got.month, got.mday, got.hour, got.minute, got.second);
      end else begin
        exp_date = pending_dates.pop_front();
        diff     = bad_fields(got, exp_date.date);
        if (diff != "") begin
          date_errors++;
          if (date_errors <= 10)
            $display({"[%0t] result %0d for %0d seconds wrong in:%s\n",
                      "    got  %0d-%0d-%0d %0d:%0d:%0d weekday %0d pad %0h\n",
                      "    want %0d-%0d-%0d %0d:%0d:%0d weekday %0d pad %0h"},
                     $realtime, results_seen, exp_date.secs, diff,
                     got.year, got.month, got.mday, got.hour, got.minute, got.second,
                     got.wday, got.pad, exp_date.date.year, exp_date.date.month,
                     exp_date.date.mday, exp_date.date.hour, exp_date.date.minute,
                     exp_date.date.second, exp_date.date.wday, exp_date.date.pad);
        end
      end
    end
  end

  // Receiver: stall at random unless a steady stretch is running
  always @(posedge clk) begin
    out_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: count cycles in which no transaction moves on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("epoch_seconds_to_calendar test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Present one timestamp, hold it until accepted, then record its date
  task automatic send_seconds(input logic [31:0] secs, input bit typed, input cal_t typed_date);
    dated_t exp_date;
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
    exp_date.secs = secs;
    exp_date.date = typed ? typed_date : calendar_of(secs);
    pending_dates.push_back(exp_date);
  endtask

  // Drop valid for a random gap; sometimes long, so gaps land in any phase
  task automatic maybe_idle();
    int unsigned gap;
    if (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_dates();
    in_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  initial begin
    table_row_t  rows[$];
    logic [31:0] secs;

    // Edge dates: the epoch itself, minute/hour/day/year turnovers, leap days
    // in an ordinary leap year, in 2000 (century divisible by 400) and the
    // missing one in 2100, the signed 32-bit rollover and the top of the range.
    rows.push_back('{32'd0,          1'b1, stamp(0, 0, 0, WD_THURSDAY, 1, 1, 1970)});
    rows.push_back('{32'd59,         1'b1, stamp(59, 0, 0, WD_THURSDAY, 1, 1, 1970)});
    rows.push_back('{32'd60,         1'b0, '0});
    rows.push_back('{32'd3599,       1'b0, '0});
    rows.push_back('{32'd3600,       1'b0, '0});
    rows.push_back('{32'd86399,      1'b1, stamp(59, 59, 23, WD_THURSDAY, 1, 1, 1970)});
    rows.push_back('{32'd86400,      1'b0, '0});
    rows.push_back('{32'd31535999,   1'b0, '0});
    rows.push_back('{32'd31536000,   1'b0, '0});
    rows.push_back('{32'd68169600,   1'b0, '0});
    rows.push_back('{32'd68255999,   1'b0, '0});
    rows.push_back('{32'd951782400,  1'b0, '0});
    rows.push_back('{32'd951868800,  1'b0, '0});
    rows.push_back('{32'd978307199,  1'b0, '0});
    rows.push_back('{32'd2147483647, 1'b0, '0});
    rows.push_back('{32'd2147483648, 1'b0, '0});
    rows.push_back('{32'd4102444800, 1'b0, '0});
    rows.push_back('{32'd4107542399, 1'b0, '0});
    rows.push_back('{32'd4107542400, 1'b0, '0});
    rows.push_back('{32'hAAAAAAAA,   1'b0, '0});
    rows.push_back('{32'h55555555,   1'b0, '0});
    rows.push_back('{32'h0000FFFF,   1'b0, '0});
    rows.push_back('{32'hFFFF0000,   1'b0, '0});
    rows.push_back('{32'hFFFFFFFF,   1'b1, stamp(15, 28, 6, WD_SUNDAY, 7, 2, 2106)});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      maybe_idle();
      send_seconds(rows[i].secs, rows[i].typed, rows[i].date);
    end

    // Hold off until the converter has drained the directed table
    wait_all_dates();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // a long run with no idling on either side
      steady_run = (i >= 200 && i < 300);
      if (i == 400) wait_all_dates();
      maybe_idle();
      case ($urandom_range(0, 3))
        0, 1:    secs = $urandom;
        2:       secs = near_boundary();
        default: secs = $urandom_range(0, 1) ? $urandom_range(0, 100000)
                                             : 32'hFFFFFFFF - $urandom_range(0, 100000);
      endcase
      send_seconds(secs, 1'b0, '0);
    end
    steady_run = 1'b0;

    wait_all_dates();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (date_errors == 0 && pending_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar test passed");
    end else begin
      $display("epoch_seconds_to_calendar test failed");
    end
    $finish;
  end

endmodule
